/* rtl/core/hgpp_pkg.sv */
// shared types and constants of the hexagon grid point picker
`timescale 1ns / 1ps
package hgpp_pkg;

  localparam int COUNT_W   = 16;
  localparam int SIZE_W    = 20;
  // positions and half sizes share this many fraction bits
  localparam int FRAC_BITS = 8;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_HALF_W  = 2'd2,
    CFG_HALF_H  = 2'd3
  } cfg_idx_t;

endpackage

/* rtl/core/hgpp_if.sv */
// request channels of the hexagon grid point picker
`timescale 1ns / 1ps
interface hgpp_point_if #(parameter int POS_BITS = 24);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic                       clamp_mode;
  modport source (output valid, pos_x, pos_y, clamp_mode, input ready);
  modport sink   (input valid, pos_x, pos_y, clamp_mode, output ready);
endinterface

interface hgpp_cell_if #(parameter int POS_BITS = 24);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] column;
  logic signed [POS_BITS-1:0] row;
  logic                       inside_grid;
  logic                       config_error;
  modport source (output valid, column, row, inside_grid, config_error, input ready);
  modport sink   (input valid, column, row, inside_grid, config_error, output ready);
endinterface

interface hgpp_cfg_if;
  logic                         valid;
  logic                         ready;
  hgpp_pkg::cfg_idx_t           index;
  logic [hgpp_pkg::SIZE_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/hgpp_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hgpp_div_pipe #(
  parameter int NW = 26,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] div,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [NW-1:0] nq [0:NW];
  logic [DW-1:0] rm [0:NW];

  assign nq[0] = num;
  assign rm[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    always_comb begin
      t    = {rm[i], nq[i][NW-1]};
      diff = t - {1'b0, div};
      ge   = (t >= {1'b0, div});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nq[i+1] <= {nq[i][NW-2:0], ge};
        rm[i+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
      end
    end
  end

  assign quo = nq[NW];
  assign rem = rm[NW];

endmodule

/* rtl/core/hex_grid_point_pick_core.sv */
// hexagon grid point picker, top level
// stages: one input stage, one divider stage per quotient bit, three fix-up
//   stages and an output register; the pipelined dividers set the depth
// throughput: one request per cycle while pick_out is not stalled
// reset: synchronous, clears valid bits and all four size registers
`timescale 1ns / 1ps
module hex_grid_point_pick_core #(
  parameter int POS_BITS  = 24
) (
  input  logic          clk,
  input  logic          rst,
  hgpp_point_if.sink    pick_in,
  hgpp_cell_if.source   pick_out,
  hgpp_cfg_if.sink      cfg
);
  import hgpp_pkg::*;

  localparam int XW = ((POS_BITS > SIZE_W) ? POS_BITS : SIZE_W + 1) + 1;
  localparam int NW = XW + 1;
  localparam int CW = NW + 1;
  localparam int DXW = SIZE_W;
  localparam int DYW = SIZE_W + 2;

  logic [COUNT_W-1:0] grid_columns;
  logic [COUNT_W-1:0] grid_rows;
  logic [SIZE_W-1:0]  half_width;
  logic [SIZE_W-1:0]  half_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= '0;
      grid_rows    <= '0;
      half_width   <= '0;
      half_height  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COLUMNS: grid_columns <= cfg.data[COUNT_W-1:0];
        CFG_ROWS:    grid_rows    <= cfg.data[COUNT_W-1:0];
        CFG_HALF_W:  half_width   <= cfg.data;
        CFG_HALF_H:  half_height  <= cfg.data;
        default:     ;
      endcase
    end
  end

  logic en;
  assign en = !pick_out.valid || pick_out.ready;
  assign pick_in.ready = en;

  logic [DYW-1:0] div3a;
  assign div3a = {2'b00, half_height} + {1'b0, half_height, 1'b0};

  // input stage
  logic signed [NW-1:0] x0, y0;
  logic                 s0_valid, s0_clamp;
  logic signed [NW-1:0] xs, ys;
  always_comb begin
    xs = NW'(pick_in.pos_x) - $signed({{(NW-SIZE_W){1'b0}}, half_width});
    ys = (NW'(pick_in.pos_y) - $signed({{(NW-SIZE_W){1'b0}}, half_height})) <<< 1;
  end
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= pick_in.valid;
    if (en) begin
      x0 <= xs;
      y0 <= ys;
      s0_clamp <= pick_in.clamp_mode;
    end
  end

  // dividers on magnitudes, floor fix-up afterwards
  logic [NW-1:0] mx, my, qx_u, qy_u;
  logic [DXW-1:0] rx_u;
  logic [DYW-1:0] ry_u;
  assign mx = x0[NW-1] ? ~x0 : x0;
  assign my = y0[NW-1] ? ~y0 : y0;

  hgpp_div_pipe #(.NW(NW), .DW(DXW)) u_div_x (
    .clk(clk), .en(en), .num(mx), .div(half_width), .quo(qx_u), .rem(rx_u)
  );
  hgpp_div_pipe #(.NW(NW), .DW(DYW)) u_div_y (
    .clk(clk), .en(en), .num(my), .div(div3a), .quo(qy_u), .rem(ry_u)
  );

  logic sv [0:NW];
  logic sc [0:NW];
  logic snx [0:NW];
  logic sny [0:NW];
  assign sv[0]  = s0_valid;
  assign sc[0]  = s0_clamp;
  assign snx[0] = x0[NW-1];
  assign sny[0] = y0[NW-1];
  for (genvar i = 0; i < NW; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (en) sv[i+1] <= sv[i];
      if (en) begin
        sc[i+1]  <= sc[i];
        snx[i+1] <= snx[i];
        sny[i+1] <= sny[i];
      end
    end
  end

  // fix-up stage one: signed quotients, parity, edge offsets
  logic signed [NW-1:0] qx, qy;
  logic [DXW-1:0] rx;
  logic [DYW-1:0] ry;
  logic           par;
  logic [DXW-1:0] dyv;
  logic signed [DYW+1:0] d2m;
  always_comb begin
    qx  = snx[NW] ? ~qx_u : qx_u;
    qy  = sny[NW] ? ~qy_u : qy_u;
    rx  = snx[NW] ? (half_width - DXW'(1) - rx_u) : rx_u;
    ry  = sny[NW] ? (div3a - DYW'(1) - ry_u) : ry_u;
    par = qx[0] ^ qy[0];
    dyv = par ? rx : (half_width - rx);
    d2m = $signed({2'b00, ry}) - $signed({{(DYW+2-SIZE_W){1'b0}}, half_height});
  end

  logic signed [NW-1:0] e1_px, e1_py;
  logic                 e1_valid, e1_clamp, e1_par;
  logic [DXW-1:0]       e1_dy;
  logic signed [DYW+1:0] e1_d2m;
  always_ff @(posedge clk) begin
    if (rst) e1_valid <= 1'b0;
    else if (en) e1_valid <= sv[NW];
    if (en) begin
      e1_px <= qx; e1_py <= qy; e1_clamp <= sc[NW]; e1_par <= par;
      e1_dy <= dyv; e1_d2m <= d2m;
    end
  end

  // fix-up stage two: edge test products
  localparam int PW = SIZE_W + DYW + 3;
  logic [2*SIZE_W-1:0]  dy_a;
  assign dy_a = (2*SIZE_W)'(e1_dy) * (2*SIZE_W)'(half_height);

  logic signed [NW-1:0] e2_px, e2_py;
  logic                 e2_valid, e2_clamp, e2_par;
  logic signed [PW-1:0] e2_p1, e2_p2;
  always_ff @(posedge clk) begin
    if (rst) e2_valid <= 1'b0;
    else if (en) e2_valid <= e1_valid;
    if (en) begin
      e2_px <= e1_px; e2_py <= e1_py; e2_clamp <= e1_clamp; e2_par <= e1_par;
      e2_p1 <= $signed({{(PW-2*SIZE_W){1'b0}}, dy_a});
      e2_p2 <= PW'(e1_d2m) * PW'($signed({1'b0, half_width}));
    end
  end

  // fix-up stage three: cell adjust and column halving
  logic                 right;
  logic signed [CW-1:0] px2, py2;
  always_comb begin
    right = e2_p1 < e2_p2;
    px2 = CW'(e2_px) + CW'({1'b0, e2_par ^ right});
    py2 = CW'(e2_py) + CW'({1'b0, right});
  end

  logic signed [CW-1:0] e3_col, e3_row;
  logic                 e3_valid, e3_clamp;
  always_ff @(posedge clk) begin
    if (rst) e3_valid <= 1'b0;
    else if (en) e3_valid <= e2_valid;
    if (en) begin
      e3_col <= px2 >>> 1;
      e3_row <= py2;
      e3_clamp <= e2_clamp;
    end
  end

  // output stage: grid test, clamp, saturate
  localparam logic signed [CW-1:0] SAT_HI = CW'({1'b0, {(POS_BITS-1){1'b1}}});
  localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);
  logic signed [CW-1:0] ncols, nrows, col_c, row_c;
  logic                 cerr, ins;
  logic signed [POS_BITS-1:0] col_o, row_o;
  always_comb begin
    ncols = $signed({{(CW-COUNT_W){1'b0}}, grid_columns});
    nrows = $signed({{(CW-COUNT_W){1'b0}}, grid_rows});
    cerr  = (grid_columns == '0) || (grid_rows == '0) ||
            (half_width == '0) || (half_height == '0);
    ins   = (e3_col >= 0) && (e3_col < ncols) && (e3_row >= 0) && (e3_row < nrows);
    col_c = e3_col;
    row_c = e3_row;
    if (e3_clamp && !ins) begin
      if (e3_col < 0) col_c = '0;
      else if (e3_col >= ncols) col_c = ncols - CW'(1);
      if (e3_row < 0) row_c = '0;
      else if (e3_row >= nrows) row_c = nrows - CW'(1);
    end
    col_o = (col_c > SAT_HI) ? SAT_HI[POS_BITS-1:0] :
            (col_c < SAT_LO) ? SAT_LO[POS_BITS-1:0] : col_c[POS_BITS-1:0];
    row_o = (row_c > SAT_HI) ? SAT_HI[POS_BITS-1:0] :
            (row_c < SAT_LO) ? SAT_LO[POS_BITS-1:0] : row_c[POS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) pick_out.valid <= 1'b0;
    else if (en) pick_out.valid <= e3_valid;
    if (en) begin
      pick_out.column       <= cerr ? '0 : col_o;
      pick_out.row          <= cerr ? '0 : row_o;
      pick_out.inside_grid  <= cerr ? 1'b0 : ins;
      pick_out.config_error <= cerr;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    pick_out.valid && pick_out.config_error |->
      pick_out.column == '0 && pick_out.row == '0 && !pick_out.inside_grid)
    else $error("config error with non-zero cell");

  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    pick_out.valid && pick_out.inside_grid |->
      pick_out.column >= 0 && pick_out.row >= 0 &&
      pick_out.column < $signed({1'b0, grid_columns}) &&
      pick_out.row < $signed({1'b0, grid_rows}))
    else $error("inside flag on cell outside grid");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(e3_valid) && $stable(e1_valid))
    else $error("pipeline moved during stall");

endmodule
